/* rtl/ckerng_pkg.sv */
package ckerng_pkg;

  localparam int KEY_BYTES = 32;
  localparam int KEY_WORDS = 8;
  localparam int MAX_REQUEST_BYTES = 64;
  localparam int SEED_REGS = 4;

  localparam logic OP_RAW   = 1'b0;
  localparam logic OP_BOUND = 1'b1;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  // one queued request between front and back
  typedef struct packed {
    logic        op;
    logic [6:0]  count;
    logic [31:0] top;
    logic [31:0] mask;
  } req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_NEED,
    BK_REFILL,
    BK_READ,
    BK_EMIT
  } bk_state_t;

  typedef enum logic [2:0] {
    CC_IDLE,
    CC_LOAD,
    CC_ROUND,
    CC_OUT,
    CC_DONE
  } cc_state_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // one ChaCha quarter round on four words
  function automatic logic [127:0] qround(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] a1, b1, c1, d1;
    a1 = a + b;   d1 = rotl(d ^ a1, 16);
    c1 = c + d1;  b1 = rotl(b ^ c1, 12);
    a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
    c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
    qround = {a1, b1, c1, d1};
  endfunction

endpackage

/* rtl/ckerng_ram.sv */
module ckerng_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 288
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ckerng_front.sv */
module ckerng_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_op,
  input  logic [6:0]          in_byte_count,
  input  logic [31:0]         in_range,
  output logic                q_valid,
  output ckerng_pkg::req_t    q_req,
  input  logic                q_pop
);

  localparam int DEPTH = 2;

  ckerng_pkg::req_t slot_r [DEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  ckerng_pkg::req_t req;
  logic [31:0] top, t, mask;
  logic        push;

  // classify: saturate count, build the mask for bounded draws
  always_comb begin
    top = in_range - 32'd1;
    t = top | 32'd1;
    mask = t;
    mask = mask | (mask >> 1);
    mask = mask | (mask >> 2);
    mask = mask | (mask >> 4);
    mask = mask | (mask >> 8);
    mask = mask | (mask >> 16);
    req.op = in_op;
    req.count = (in_byte_count > 7'(ckerng_pkg::MAX_REQUEST_BYTES)) ?
                7'(ckerng_pkg::MAX_REQUEST_BYTES) : in_byte_count;
    req.top = top;
    req.mask = mask;
  end

  assign busy = (cnt_r == 2'(DEPTH));
  // drop raw requests of zero bytes
  assign push = start && !busy && (in_op == ckerng_pkg::OP_BOUND || req.count != 7'd0);
  assign q_valid = (cnt_r != 2'd0);
  assign q_req = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= req;
    end
  end

endmodule

/* rtl/ckerng_core.sv */
module ckerng_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  logic [255:0]   key,
  input  logic [31:0]    blk,
  output logic           busy,
  output logic           wvalid,
  output logic [5:0]     widx,
  output logic [7:0]     wbyte
);

  ckerng_pkg::cc_state_t st_r, st_nxt;
  logic [31:0] in_r [16];
  logic [31:0] w_r  [16];
  logic [4:0]  rnd_r;
  logic [5:0]  idx_r;
  logic [31:0] w_nxt [16];
  logic [31:0] sum;

  // one column or diagonal half-round per cycle
  always_comb begin
    logic [127:0] q0, q1, q2, q3;
    for (int i = 0; i < 16; i++) w_nxt[i] = w_r[i];
    if (!rnd_r[0]) begin
      q0 = ckerng_pkg::qround(w_r[0], w_r[4], w_r[8],  w_r[12]);
      q1 = ckerng_pkg::qround(w_r[1], w_r[5], w_r[9],  w_r[13]);
      q2 = ckerng_pkg::qround(w_r[2], w_r[6], w_r[10], w_r[14]);
      q3 = ckerng_pkg::qround(w_r[3], w_r[7], w_r[11], w_r[15]);
      {w_nxt[0], w_nxt[4], w_nxt[8],  w_nxt[12]} = q0;
      {w_nxt[1], w_nxt[5], w_nxt[9],  w_nxt[13]} = q1;
      {w_nxt[2], w_nxt[6], w_nxt[10], w_nxt[14]} = q2;
      {w_nxt[3], w_nxt[7], w_nxt[11], w_nxt[15]} = q3;
    end else begin
      q0 = ckerng_pkg::qround(w_r[0], w_r[5], w_r[10], w_r[15]);
      q1 = ckerng_pkg::qround(w_r[1], w_r[6], w_r[11], w_r[12]);
      q2 = ckerng_pkg::qround(w_r[2], w_r[7], w_r[8],  w_r[13]);
      q3 = ckerng_pkg::qround(w_r[3], w_r[4], w_r[9],  w_r[14]);
      {w_nxt[0], w_nxt[5], w_nxt[10], w_nxt[15]} = q0;
      {w_nxt[1], w_nxt[6], w_nxt[11], w_nxt[12]} = q1;
      {w_nxt[2], w_nxt[7], w_nxt[8],  w_nxt[13]} = q2;
      {w_nxt[3], w_nxt[4], w_nxt[9],  w_nxt[14]} = q3;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ckerng_pkg::CC_IDLE:  if (go) st_nxt = ckerng_pkg::CC_LOAD;
      ckerng_pkg::CC_LOAD:  st_nxt = ckerng_pkg::CC_ROUND;
      ckerng_pkg::CC_ROUND: if (rnd_r == 5'd19) st_nxt = ckerng_pkg::CC_OUT;
      ckerng_pkg::CC_OUT:   if (idx_r == 6'd63) st_nxt = ckerng_pkg::CC_DONE;
      ckerng_pkg::CC_DONE:  st_nxt = ckerng_pkg::CC_IDLE;
      default:              st_nxt = ckerng_pkg::CC_IDLE;
    endcase
  end

  assign sum = w_r[idx_r[5:2]] + in_r[idx_r[5:2]];

  always_comb begin
    busy = (st_r != ckerng_pkg::CC_IDLE) || go;
    wvalid = (st_r == ckerng_pkg::CC_OUT);
    widx = idx_r;
    wbyte = sum[8*idx_r[1:0] +: 8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ckerng_pkg::CC_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ckerng_pkg::CC_IDLE: begin
        if (go) begin
          in_r[0] <= ckerng_pkg::SIGMA0;
          in_r[1] <= ckerng_pkg::SIGMA1;
          in_r[2] <= ckerng_pkg::SIGMA2;
          in_r[3] <= ckerng_pkg::SIGMA3;
          for (int i = 0; i < 8; i++) in_r[4+i] <= key[32*i +: 32];
          in_r[12] <= blk;
          in_r[13] <= '0;
          in_r[14] <= '0;
          in_r[15] <= '0;
        end
      end
      ckerng_pkg::CC_LOAD: begin
        for (int i = 0; i < 16; i++) w_r[i] <= in_r[i];
        rnd_r <= '0;
        idx_r <= '0;
      end
      ckerng_pkg::CC_ROUND: begin
        for (int i = 0; i < 16; i++) w_r[i] <= w_nxt[i];
        rnd_r <= rnd_r + 5'd1;
      end
      ckerng_pkg::CC_OUT: idx_r <= idx_r + 6'd1;
      default: ;
    endcase
  end

endmodule

/* rtl/ckerng_back.sv */
module ckerng_back #(
  parameter int STREAM_BYTES = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  ckerng_pkg::req_t q_req,
  output logic             q_pop,
  input  logic [255:0]     seed,
  output logic             out_valid,
  output logic [31:0]      out_value,
  output logic             out_last
);

  localparam int BUF = ckerng_pkg::KEY_BYTES + STREAM_BYTES;
  localparam int AW = $clog2(BUF + 1);
  localparam int NBLK = (BUF + 63) / 64;
  localparam int BW = $clog2(NBLK + 1);

  ckerng_pkg::bk_state_t st_r, st_nxt;
  logic [AW-1:0] rd_r;
  logic          keyed_r;
  logic [255:0]  key_r;
  logic [255:0]  nkey_r;
  logic [BW-1:0] blk_r;
  logic          go_r;
  logic [6:0]    left_r;
  logic [1:0]    bcnt_r;
  logic [31:0]   acc_r;
  logic          cc_busy, cc_wv;
  logic [5:0]    cc_idx;
  logic [7:0]    cc_byte;
  logic [AW-1:0] wpos;
  logic [7:0]    rdata;
  logic          we;
  logic [31:0]   acc_nxt, draw;
  logic          take;

  assign wpos = AW'({blk_r, cc_idx});
  assign we = cc_wv && (wpos < AW'(BUF));

  ckerng_ram #(.WIDTH(8), .DEPTH(BUF)) u_buf (
    .clk   (clk),
    .we    (we),
    .waddr (wpos[$clog2(BUF)-1:0]),
    .wdata (cc_byte),
    .raddr (rd_r[$clog2(BUF)-1:0]),
    .rdata (rdata)
  );

  ckerng_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go_r),
    .key    (key_r),
    .blk    (32'(blk_r)),
    .busy   (cc_busy),
    .wvalid (cc_wv),
    .widx   (cc_idx),
    .wbyte  (cc_byte)
  );

  assign acc_nxt = {acc_r[23:0], rdata};
  assign draw = acc_nxt & q_req.mask;
  assign take = (st_r == ckerng_pkg::BK_EMIT);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ckerng_pkg::BK_IDLE:
        if (q_valid) st_nxt = ckerng_pkg::BK_NEED;
      ckerng_pkg::BK_NEED:
        st_nxt = (rd_r >= AW'(BUF)) ? ckerng_pkg::BK_REFILL : ckerng_pkg::BK_READ;
      ckerng_pkg::BK_REFILL:
        if (!cc_busy && !go_r && blk_r == BW'(NBLK)) st_nxt = ckerng_pkg::BK_READ;
      ckerng_pkg::BK_READ:
        st_nxt = ckerng_pkg::BK_EMIT;
      ckerng_pkg::BK_EMIT: begin
        if (q_req.op == ckerng_pkg::OP_RAW) begin
          st_nxt = (left_r == 7'd1) ? ckerng_pkg::BK_IDLE : ckerng_pkg::BK_NEED;
        end else if (bcnt_r == 2'd3 && draw <= q_req.top) begin
          st_nxt = ckerng_pkg::BK_IDLE;
        end else begin
          st_nxt = ckerng_pkg::BK_NEED;
        end
      end
      default: st_nxt = ckerng_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    out_valid = 1'b0;
    out_value = {24'd0, rdata};
    out_last = 1'b0;
    q_pop = 1'b0;
    if (take) begin
      if (q_req.op == ckerng_pkg::OP_RAW) begin
        out_valid = 1'b1;
        out_last = (left_r == 7'd1);
        q_pop = out_last;
      end else if (bcnt_r == 2'd3 && draw <= q_req.top) begin
        out_valid = 1'b1;
        out_value = draw;
        out_last = 1'b1;
        q_pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ckerng_pkg::BK_IDLE;
      rd_r <= AW'(BUF);
      keyed_r <= 1'b0;
      go_r <= 1'b0;
      blk_r <= '0;
    end else begin
      st_r <= st_nxt;
      go_r <= 1'b0;
      // start a refill: seed key on first use, then blocks in turn
      if (st_r == ckerng_pkg::BK_NEED && rd_r >= AW'(BUF)) begin
        if (!keyed_r) key_r <= seed;
        keyed_r <= 1'b1;
        blk_r <= '0;
        go_r <= 1'b1;
      end else if (st_r == ckerng_pkg::BK_REFILL && !cc_busy && !go_r) begin
        if (blk_r != BW'(NBLK)) begin
          blk_r <= blk_r + BW'(1);
          if (blk_r + BW'(1) != BW'(NBLK)) go_r <= 1'b1;
          else begin
            key_r <= nkey_r;
            rd_r <= AW'(ckerng_pkg::KEY_BYTES);
          end
        end
      end
      if (take) rd_r <= rd_r + AW'(1);
    end
  end

  // capture next key from the first 32 bytes of block 0, track request progress
  always_ff @(posedge clk) begin
    if (cc_wv && blk_r == '0 && !cc_idx[5]) nkey_r[8*cc_idx[4:0] +: 8] <= cc_byte;
    if (st_r == ckerng_pkg::BK_IDLE) begin
      left_r <= q_req.count;
      bcnt_r <= '0;
    end
    if (take) begin
      left_r <= left_r - 7'd1;
      bcnt_r <= bcnt_r + 2'd1;
      acc_r <= acc_nxt;
    end
  end

endmodule

/* rtl/chacha20_key_erasure_rng.sv */
// Random generator with fast key erasure over ChaCha20. Issue a request with
// start while busy is low; a two-deep request queue takes requests while
// earlier ones run. Results appear with out_valid for one cycle each and
// cannot be stalled. A raw byte is read from the byte buffer through the NEED,
// READ and EMIT states; a bounded draw reads four bytes that way per attempt.
// Every 256 stream bytes the buffer is refilled by one shared ChaCha20 round
// unit: five blocks, each 20 half-rounds then 64 bytes for the buffer RAM.
// Seed registers are read at the first refill after reset only.
module chacha20_key_erasure_rng #(
  parameter int STREAM_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [6:0]  in_byte_count,
  input  logic [31:0] in_range,
  output logic        out_valid,
  output logic [31:0] out_value,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] seed_r [ckerng_pkg::SEED_REGS];
  logic             q_valid, q_pop;
  ckerng_pkg::req_t q_req;

  assign cfg_ready = 1'b1;

  // hold seed registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ckerng_pkg::SEED_REGS; i++) seed_r[i] <= '0;
    end else if (cfg_valid) begin
      seed_r[cfg_index] <= cfg_data;
    end
  end

  ckerng_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_byte_count (in_byte_count),
    .in_range      (in_range),
    .q_valid       (q_valid),
    .q_req         (q_req),
    .q_pop         (q_pop)
  );

  ckerng_back #(.STREAM_BYTES(STREAM_BYTES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .seed      ({seed_r[3], seed_r[2], seed_r[1], seed_r[0]}),
    .out_valid (out_valid),
    .out_value (out_value),
    .out_last  (out_last)
  );

endmodule

/* verif/chacha20_key_erasure_rng_test.sv */
module chacha20_key_erasure_rng_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STREAM_LEN = 256;
  localparam int POOL_LEN   = ckerng_pkg::KEY_BYTES + STREAM_LEN;
  localparam int SETTLE     = 700;
  localparam int LIMIT      = 600000;
  localparam int RANDOM_REQS = 160;

  typedef struct {
    logic        op;
    logic [6:0]  count;
    logic [31:0] range;
    bit          typed;
    logic [31:0] value;
  } row_t;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } draw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_op = ckerng_pkg::OP_RAW;
  logic [6:0]  in_byte_count = '0;
  logic [31:0] in_range = '0;
  logic        out_valid;
  logic [31:0] out_value;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // predictor state
  logic [7:0]  pool [POOL_LEN];
  int          pool_pos;
  bit          pool_keyed;
  logic [63:0] seed_key [ckerng_pkg::SEED_REGS];

  draw_t       pending_draws [$];
  int          errors;
  int          cycles = 0;

  chacha20_key_erasure_rng #(.STREAM_BYTES(STREAM_LEN)) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_byte_count(in_byte_count),
    .in_range     (in_range),
    .out_valid    (out_valid),
    .out_value    (out_value),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [31:0] spin(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // mix four words of the working state in place
  task automatic mix(ref logic [31:0] s [16], input int a, input int b, input int c,
                     input int d);
    s[a] += s[b]; s[d] = spin(s[d] ^ s[a], 16);
    s[c] += s[d]; s[b] = spin(s[b] ^ s[c], 12);
    s[a] += s[b]; s[d] = spin(s[d] ^ s[a], 8);
    s[c] += s[d]; s[b] = spin(s[b] ^ s[c], 7);
  endtask

  // overwrite the whole pool with fresh keystream; the head becomes the next key
  task automatic rekey_pool();
    logic [31:0] init [16];
    logic [31:0] work [16];
    logic [31:0] word;
    int pos;
    int blk;
    pos = 0;
    blk = 0;
    if (!pool_keyed) begin
      for (int i = 0; i < ckerng_pkg::KEY_BYTES; i++)
        pool[i] = seed_key[i / 8][8 * (i % 8) +: 8];
      pool_keyed = 1'b1;
    end
    init[0] = ckerng_pkg::SIGMA0; init[1] = ckerng_pkg::SIGMA1;
    init[2] = ckerng_pkg::SIGMA2; init[3] = ckerng_pkg::SIGMA3;
    for (int i = 0; i < ckerng_pkg::KEY_WORDS; i++)
      init[4 + i] = {pool[4 * i + 3], pool[4 * i + 2], pool[4 * i + 1], pool[4 * i]};
    init[13] = '0; init[14] = '0; init[15] = '0;
    while (pos < POOL_LEN) begin
      init[12] = 32'(blk);
      work = init;
      for (int r = 0; r < 10; r++) begin
        mix(work, 0, 4, 8, 12); mix(work, 1, 5, 9, 13);
        mix(work, 2, 6, 10, 14); mix(work, 3, 7, 11, 15);
        mix(work, 0, 5, 10, 15); mix(work, 1, 6, 11, 12);
        mix(work, 2, 7, 8, 13); mix(work, 3, 4, 9, 14);
      end
      for (int i = 0; i < 64 && pos < POOL_LEN; i++) begin
        word = work[i / 4] + init[i / 4];
        pool[pos] = word[8 * (i % 4) +: 8];
        pos++;
      end
      blk++;
    end
    pool_pos = ckerng_pkg::KEY_BYTES;
  endtask

  task automatic next_byte(output logic [7:0] b);
    if (pool_pos >= POOL_LEN) rekey_pool();
    b = pool[pool_pos];
    pool_pos++;
  endtask

  // work out the results of one request and queue them
  task automatic predict_request(input logic op, input logic [6:0] count,
                                 input logic [31:0] range, input bit typed,
                                 input logic [31:0] typed_value);
    int n;
    logic [31:0] top;
    logic [31:0] t;
    logic [31:0] mask;
    logic [31:0] x;
    logic [7:0]  b;
    draw_t       d;
    if (op == ckerng_pkg::OP_RAW) begin
      n = (count > ckerng_pkg::MAX_REQUEST_BYTES) ? ckerng_pkg::MAX_REQUEST_BYTES : count;
      for (int k = 0; k < n; k++) begin
        next_byte(b);
        d.value = {24'h0, b};
        d.last = (k + 1 == n);
        pending_draws.push_back(d);
      end
    end else begin
      top = range - 32'd1;
      t = top | 32'd1;
      mask = '0;
      while (t != 0) begin
        mask = (mask << 1) | 32'd1;
        t >>= 1;
      end
      do begin
        x = '0;
        for (int j = 0; j < 4; j++) begin
          next_byte(b);
          x = (x << 8) | {24'h0, b};
        end
        x &= mask;
      end while (x > top);
      d.value = typed ? typed_value : x;
      d.last = 1'b1;
      pending_draws.push_back(d);
    end
  endtask

  // check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_draws.size() == 0) begin
        report("unexpected beat", out_value, '0);
      end else begin
        if (out_value !== pending_draws[0].value)
          report("value", out_value, pending_draws[0].value);
        if (out_last !== pending_draws[0].last)
          report("last", {31'h0, out_last}, {31'h0, pending_draws[0].last});
        void'(pending_draws.pop_front());
      end
    end
  end

  // write one seed register; valid stays up for back-to-back writes
  task automatic write_seed(input int idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx[1:0];
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    seed_key[idx] = data;
  endtask

  task automatic write_all_seeds(input logic [63:0] d0, input logic [63:0] d1,
                                 input logic [63:0] d2, input logic [63:0] d3);
    write_seed(0, d0);
    write_seed(1, d1);
    write_seed(2, d2);
    write_seed(3, d3);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every expected beat has come, then let a refill finish
  task automatic drain();
    start <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // issue one request, holding start high until busy allows it
  task automatic issue(input logic op, input logic [6:0] count, input logic [31:0] range,
                       input int gap, input bit typed, input logic [31:0] typed_value);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_byte_count <= count;
    in_range <= range;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(op, count, range, typed, typed_value);
  endtask

  function automatic int pick_gap(input bit quiet);
    if (quiet || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(1, 5);
  endfunction

  row_t directed [$];
  row_t r;

  initial begin
    int gap;
    logic [6:0] cnt;
    logic [31:0] rng;
    logic op;
    errors = 0;
    pool_pos = POOL_LEN;
    pool_keyed = 1'b0;
    foreach (seed_key[i]) seed_key[i] = '0;
    foreach (pool[i]) pool[i] = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // seeds: all ones first, then the key that is actually used
    write_all_seeds('1, '1, '1, '1);
    write_all_seeds({$urandom, $urandom}, {$urandom, $urandom}, 64'h0, '1);

    // directed part: extremes, both ops, zero and oversized counts
    directed = '{
      '{ckerng_pkg::OP_RAW,   7'd1,   32'd0,          0, 32'd0},
      '{ckerng_pkg::OP_RAW,   7'd0,   32'd0,          0, 32'd0},
      '{ckerng_pkg::OP_BOUND, 7'd0,   32'd1,          1, 32'd0},
      '{ckerng_pkg::OP_BOUND, 7'd0,   32'd0,          0, 32'd0},
      '{ckerng_pkg::OP_RAW,   7'd64,  32'd0,          0, 32'd0},
      '{ckerng_pkg::OP_RAW,   7'd127, 32'hFFFF_FFFF,  0, 32'd0},
      '{ckerng_pkg::OP_RAW,   7'd65,  32'd0,          0, 32'd0},
      '{ckerng_pkg::OP_BOUND, 7'd127, 32'd2,          0, 32'd0},
      '{ckerng_pkg::OP_BOUND, 7'd0,   32'hFFFF_FFFF,  0, 32'd0},
      '{ckerng_pkg::OP_BOUND, 7'd0,   32'h8000_0000,  0, 32'd0},
      '{ckerng_pkg::OP_BOUND, 7'd0,   32'h8000_0001,  0, 32'd0},
      '{ckerng_pkg::OP_BOUND, 7'd0,   32'd3,          0, 32'd0},
      '{ckerng_pkg::OP_BOUND, 7'd0,   32'h1234_5678,  0, 32'd0},
      '{ckerng_pkg::OP_RAW,   7'd0,   32'd0,          0, 32'd0},
      '{ckerng_pkg::OP_RAW,   7'd100, 32'd0,          0, 32'd0},
      '{ckerng_pkg::OP_BOUND, 7'd5,   32'd1,          1, 32'd0},
      '{ckerng_pkg::OP_RAW,   7'd63,  32'd0,          0, 32'd0},
      '{ckerng_pkg::OP_RAW,   7'd32,  32'd0,          0, 32'd0},
      '{ckerng_pkg::OP_BOUND, 7'd0,   32'd256,        0, 32'd0},
      '{ckerng_pkg::OP_RAW,   7'd64,  32'd0,          0, 32'd0}
    };
    foreach (directed[i]) begin
      r = directed[i];
      issue(r.op, r.count, r.range, pick_gap(0), r.typed, r.value);
    end
    drain();

    // seed writes after keying must change nothing
    write_all_seeds('0, '0, '0, '0);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i == RANDOM_REQS / 2) begin
        drain();
        write_all_seeds('1, {$urandom, $urandom}, '1, '0);
      end
      op = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       cnt = 7'($urandom_range(0, 127));
        1:       cnt = 7'(ckerng_pkg::MAX_REQUEST_BYTES);
        default: cnt = 7'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 5))
        0:       rng = $urandom_range(0, 3);
        1:       rng = 32'h8000_0000 | $urandom_range(0, 3);
        2:       rng = $urandom >> $urandom_range(0, 31);
        default: rng = $urandom;
      endcase
      gap = pick_gap(i >= RANDOM_REQS - 30);
      issue(op, cnt, rng, gap, 0, 32'd0);
    end
    drain();

    if (pending_draws.size() != 0) begin
      report("leftover beats", pending_draws.size(), 0);
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ckerng_pkg.sv
rtl/ckerng_ram.sv
rtl/ckerng_front.sv
rtl/ckerng_core.sv
rtl/ckerng_back.sv
rtl/chacha20_key_erasure_rng.sv
verif/chacha20_key_erasure_rng_test.sv
